FILE: rtl/core/taag_pkg.sv
// Shared types, widths and constants of the tiled array address generator.
package taag_pkg;

    localparam int SIZE_W      = 13;
    localparam int NUM_SIZES   = 4;
    localparam int NDIM_REG_W  = 3;
    localparam int LIMIT_W     = 25;
    localparam int WORD_W      = 32;
    localparam int ADDR_W      = 51;
    localparam int MUL_W       = 64;
    localparam int CNT_W       = 4;
    localparam int NUM_REGS    = 7;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;
    localparam int HDR_W       = 10;

    localparam int DEF_MAX_DIM_POINTS = 4096;
    localparam int DEF_MAX_DIMS       = 4;

    // file header length for 2, 3 and 4 dimensions
    localparam logic [HDR_W-1:0] HDR_2D = 10'd436;
    localparam logic [HDR_W-1:0] HDR_3D = 10'd564;
    localparam logic [HDR_W-1:0] HDR_4D = 10'd692;

    localparam logic [SIZE_W-1:0]     RST_SIZE  = 13'd1;
    localparam logic [NDIM_REG_W-1:0] RST_NDIMS = 3'd2;
    localparam logic [LIMIT_W-1:0]    RST_LIMIT = 25'd32768;

    typedef enum logic [2:0] {
        REG_SIZE0 = 3'd0,
        REG_SIZE1 = 3'd1,
        REG_SIZE2 = 3'd2,
        REG_SIZE3 = 3'd3,
        REG_NDIMS = 3'd4,
        REG_LIMIT = 3'd5,
        REG_SWAP  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [NUM_SIZES-1:0][SIZE_W-1:0] size;
        logic [NDIM_REG_W-1:0]            num_dims;
        logic [LIMIT_W-1:0]               max_tile_elems;
        logic                             swap_bytes;
    } cfg_t;

    typedef enum logic [1:0] {
        MUL_P  = 2'd0,
        MUL_SO = 2'd1,
        MUL_SB = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     td_load;
        logic     halve;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     p_take;
        logic     str_init;
        logic     div_start;
        logic     div_take;
        logic     str_store;
        logic     so_take;
        logic     sb_take;
        logic     cnt_init;
        logic     item_take;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
        logic fits;
        logic out_free;
    } dp_sts_t;

endpackage

FILE: rtl/core/taag_regs.sv
// APB-style configuration register file.
module taag_regs import taag_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg,
    output logic               cfg_wr
);

    cfg_t     cfg_reg;
    reg_idx_t addr_idx;

    assign addr_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign pready   = 1'b1;
    // only writes that land on a real register count
    assign cfg_wr   = psel && penable && pwrite &&
                      (32'(paddr[PADDR_W-1:2]) < NUM_REGS);
    assign cfg      = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.size           <= {NUM_SIZES{RST_SIZE}};
            cfg_reg.num_dims       <= RST_NDIMS;
            cfg_reg.max_tile_elems <= RST_LIMIT;
            cfg_reg.swap_bytes     <= 1'b0;
        end else if (cfg_wr) begin
            unique case (addr_idx)
                REG_SIZE0: cfg_reg.size[0]        <= pwdata[SIZE_W-1:0];
                REG_SIZE1: cfg_reg.size[1]        <= pwdata[SIZE_W-1:0];
                REG_SIZE2: cfg_reg.size[2]        <= pwdata[SIZE_W-1:0];
                REG_SIZE3: cfg_reg.size[3]        <= pwdata[SIZE_W-1:0];
                REG_NDIMS: cfg_reg.num_dims       <= pwdata[NDIM_REG_W-1:0];
                REG_LIMIT: cfg_reg.max_tile_elems <= pwdata[LIMIT_W-1:0];
                REG_SWAP:  cfg_reg.swap_bytes     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (addr_idx)
            REG_SIZE0: prdata = PDATA_W'(cfg_reg.size[0]);
            REG_SIZE1: prdata = PDATA_W'(cfg_reg.size[1]);
            REG_SIZE2: prdata = PDATA_W'(cfg_reg.size[2]);
            REG_SIZE3: prdata = PDATA_W'(cfg_reg.size[3]);
            REG_NDIMS: prdata = PDATA_W'(cfg_reg.num_dims);
            REG_LIMIT: prdata = PDATA_W'(cfg_reg.max_tile_elems);
            REG_SWAP:  prdata = PDATA_W'(cfg_reg.swap_bytes);
            default:   prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/taag_ctrl.sv
// Controller: setup sequencer and per-sample transfer control.
module taag_ctrl import taag_pkg::*; #(
    parameter int MAX_DIMS = DEF_MAX_DIMS,
    localparam int IDX_W   = (MAX_DIMS > 2) ? $clog2(MAX_DIMS) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr,
    input  logic             s_valid,
    output logic             s_ready,
    input  dp_sts_t          sts,
    input  logic [IDX_W-1:0] last_dim,
    output dp_cmd_t          cmd,
    output logic [IDX_W-1:0] dim_idx
);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_OUT    = 13'b0000000000010,
        ST_INIT   = 13'b0000000000100,
        ST_PMUL   = 13'b0000000001000,
        ST_PWAIT  = 13'b0000000010000,
        ST_CHECK  = 13'b0000000100000,
        ST_DIV    = 13'b0000001000000,
        ST_DWAIT  = 13'b0000010000000,
        ST_SSTORE = 13'b0000100000000,
        ST_SOWAIT = 13'b0001000000000,
        ST_SBMUL  = 13'b0010000000000,
        ST_SBWAIT = 13'b0100000000000,
        ST_FINISH = 13'b1000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             setup_done_reg, setup_done_next;

    assign dim_idx = idx_reg;
    assign s_ready = (state_reg == ST_IDLE) && setup_done_reg;

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        setup_done_next = setup_done_reg;
        cmd             = '0;
        cmd.mul_sel     = MUL_P;

        unique case (state_reg)
            ST_IDLE: begin
                if (!setup_done_reg) begin
                    // a setup cut short may leave the multiplier or divider running
                    if (!sts.mul_busy && !sts.div_busy) begin
                        state_next = ST_INIT;
                    end
                end else if (s_valid) begin
                    cmd.item_take = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_INIT: begin
                cmd.td_load = 1'b1;
                idx_next    = '0;
                state_next  = ST_PMUL;
            end
            ST_PMUL: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_P;
                state_next    = ST_PWAIT;
            end
            ST_PWAIT: begin
                if (!sts.mul_busy) begin
                    cmd.p_take = 1'b1;
                    if (idx_reg == last_dim) begin
                        state_next = ST_CHECK;
                    end else begin
                        idx_next   = IDX_W'(idx_reg + 1'b1);
                        state_next = ST_PMUL;
                    end
                end
            end
            ST_CHECK: begin
                idx_next = '0;
                if (sts.fits) begin
                    cmd.str_init = 1'b1;
                    state_next   = ST_DIV;
                end else begin
                    cmd.halve  = 1'b1;
                    state_next = ST_PMUL;
                end
            end
            ST_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (!sts.div_busy) begin
                    cmd.div_take = 1'b1;
                    if (idx_reg == last_dim) begin
                        state_next = ST_SSTORE;
                    end else begin
                        idx_next   = IDX_W'(idx_reg + 1'b1);
                        state_next = ST_DIV;
                    end
                end
            end
            ST_SSTORE: begin
                cmd.str_store = 1'b1;
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_SO;
                state_next    = ST_SOWAIT;
            end
            ST_SOWAIT: begin
                if (!sts.mul_busy) begin
                    cmd.so_take = 1'b1;
                    state_next  = ST_SBMUL;
                end
            end
            ST_SBMUL: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_SB;
                state_next    = ST_SBWAIT;
            end
            ST_SBWAIT: begin
                if (!sts.mul_busy) begin
                    cmd.sb_take = 1'b1;
                    if (idx_reg == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        idx_next   = IDX_W'(idx_reg - 1'b1);
                        state_next = ST_SSTORE;
                    end
                end
            end
            ST_FINISH: begin
                cmd.cnt_init    = 1'b1;
                setup_done_next = 1'b1;
                state_next      = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        // a register write restarts setup from scratch
        if (cfg_wr) begin
            setup_done_next = 1'b0;
            if (state_reg != ST_IDLE && state_reg != ST_OUT) begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            setup_done_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            setup_done_reg <= setup_done_next;
        end
    end

endmodule

FILE: rtl/core/taag_dp.sv
// Datapath: tile shape registers, serial multiplier and divider, coordinate lanes.
module taag_dp import taag_pkg::*; #(
    parameter int MAX_DIM_POINTS = DEF_MAX_DIM_POINTS,
    parameter int MAX_DIMS       = DEF_MAX_DIMS,
    localparam int IDX_W         = (MAX_DIMS > 2) ? $clog2(MAX_DIMS) : 1,
    localparam int ND_W          = $clog2(MAX_DIMS + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  dp_cmd_t           cmd,
    input  logic [IDX_W-1:0]  dim_idx,
    output logic [IDX_W-1:0]  last_dim,
    output dp_sts_t           sts,
    input  logic [WORD_W-1:0] s_sample_word,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ADDR_W-1:0] m_byte_address,
    output logic [WORD_W-1:0] m_out_word,
    output logic              m_last_sample
);

    localparam int HALF = (MAX_DIMS + 1) / 2;

    // effective configuration
    logic [ND_W-1:0]    nd;
    logic [SIZE_W-1:0]  size_eff [MAX_DIMS];
    logic [MAX_DIMS-1:0] used;
    logic [LIMIT_W-1:0] limit_eff;
    logic [HDR_W-1:0]   hdr;

    // tile shape
    logic [SIZE_W-1:0]  td_reg [MAX_DIMS];
    logic [SIZE_W-1:0]  tc_reg [MAX_DIMS];
    logic [MUL_W-1:0]   p_reg;
    logic [ADDR_W-1:0]  sox_reg, sbx_reg, jtmp_reg;
    logic [ADDR_W-1:0]  stepo_reg [MAX_DIMS];
    logic [ADDR_W-1:0]  jump_reg  [MAX_DIMS];

    // shift-add multiplier
    logic [MUL_W-1:0]   mul_a_reg, mul_acc_reg, mul_a_sel;
    logic [SIZE_W-1:0]  mul_b_reg, mul_b_sel;
    logic [CNT_W-1:0]   mul_cnt_reg;

    // restoring divider
    logic [SIZE_W-1:0]  div_rem_reg, div_q_reg, div_d_reg;
    logic [SIZE_W:0]    div_rem_sh;
    logic [CNT_W-1:0]   div_cnt_reg;

    // coordinate lanes
    logic [SIZE_W-1:0]  coord_reg [MAX_DIMS];
    logic [SIZE_W-1:0]  to_reg    [MAX_DIMS];
    logic [ADDR_W-1:0]  c_reg     [MAX_DIMS];
    logic [MAX_DIMS-1:0] coord_max, to_max;
    logic [MAX_DIMS:0]  carry;
    logic               last_now, all_one;
    logic [ADDR_W-1:0]  sum_lo, sum_hi;

    logic [ADDR_W-1:0]  s_lo_reg, s_hi_reg;
    logic [WORD_W-1:0]  word_reg;
    logic               last_reg;

    logic               m_valid_reg;
    logic [ADDR_W-1:0]  addr_out_reg;
    logic [WORD_W-1:0]  word_out_reg;
    logic               last_out_reg;

    always_comb begin
        if (cfg.num_dims < NDIM_REG_W'(2)) begin
            nd = ND_W'(2);
        end else if (32'(cfg.num_dims) > MAX_DIMS) begin
            nd = ND_W'(MAX_DIMS);
        end else begin
            nd = ND_W'(cfg.num_dims);
        end
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (cfg.size[d] == '0) begin
                size_eff[d] = SIZE_W'(1);
            end else if (32'(cfg.size[d]) > MAX_DIM_POINTS) begin
                size_eff[d] = SIZE_W'(MAX_DIM_POINTS);
            end else begin
                size_eff[d] = cfg.size[d];
            end
            used[d] = (32'(d) < 32'(nd));
        end
        limit_eff = (cfg.max_tile_elems == '0) ? LIMIT_W'(1) : cfg.max_tile_elems;
        case (nd)
            ND_W'(2): hdr = HDR_2D;
            ND_W'(3): hdr = HDR_3D;
            default:  hdr = HDR_4D;
        endcase
    end

    assign last_dim = IDX_W'(nd - 1'b1);

    always_comb begin
        all_one = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (used[d] && td_reg[d] > SIZE_W'(1)) begin
                all_one = 1'b0;
            end
        end
    end

    assign sts.fits     = (p_reg <= MUL_W'(limit_eff)) || all_one;
    assign sts.mul_busy = (mul_cnt_reg != '0);
    assign sts.div_busy = (div_cnt_reg != '0);
    assign sts.out_free = !m_valid_reg || m_ready;

    // ---------------- setup ----------------
    always_comb begin
        case (cmd.mul_sel)
            MUL_SO:  mul_a_sel = MUL_W'(sox_reg);
            MUL_SB:  mul_a_sel = MUL_W'(sbx_reg);
            default: mul_a_sel = p_reg;
        endcase
        mul_b_sel = (cmd.mul_sel == MUL_SB) ? tc_reg[dim_idx] : td_reg[dim_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_cnt_reg <= '0;
        end else if (cmd.mul_start) begin
            mul_cnt_reg <= CNT_W'(SIZE_W);
        end else if (mul_cnt_reg != '0) begin
            mul_cnt_reg <= CNT_W'(mul_cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            mul_a_reg   <= mul_a_sel;
            mul_b_reg   <= mul_b_sel;
            mul_acc_reg <= '0;
        end else if (mul_cnt_reg != '0) begin
            if (mul_b_reg[0]) begin
                mul_acc_reg <= mul_acc_reg + mul_a_reg;
            end
            mul_a_reg <= {mul_a_reg[MUL_W-2:0], 1'b0};
            mul_b_reg <= {1'b0, mul_b_reg[SIZE_W-1:1]};
        end
    end

    assign div_rem_sh = {div_rem_reg, div_q_reg[SIZE_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_start) begin
            div_cnt_reg <= CNT_W'(SIZE_W);
        end else if (div_cnt_reg != '0) begin
            div_cnt_reg <= CNT_W'(div_cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            div_rem_reg <= '0;
            div_q_reg   <= size_eff[dim_idx];
            div_d_reg   <= td_reg[dim_idx];
        end else if (div_cnt_reg != '0) begin
            if (div_rem_sh >= {1'b0, div_d_reg}) begin
                div_rem_reg <= SIZE_W'(div_rem_sh - {1'b0, div_d_reg});
                div_q_reg   <= {div_q_reg[SIZE_W-2:0], 1'b1};
            end else begin
                div_rem_reg <= div_rem_sh[SIZE_W-1:0];
                div_q_reg   <= {div_q_reg[SIZE_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.td_load) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                td_reg[d] <= used[d] ? size_eff[d] : '0;
                tc_reg[d] <= '0;
            end
            p_reg <= MUL_W'(1);
        end else if (cmd.halve) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                if (used[d]) begin
                    td_reg[d] <= (td_reg[d] > SIZE_W'(1)) ? (td_reg[d] >> 1) : SIZE_W'(1);
                end
            end
            p_reg <= MUL_W'(1);
        end else if (cmd.p_take) begin
            p_reg <= mul_acc_reg;
        end
        if (cmd.div_take) begin
            tc_reg[dim_idx] <= div_q_reg;
        end
        // strides walk from the innermost dimension of the layout outward
        if (cmd.str_init) begin
            sox_reg <= ADDR_W'(4);
            sbx_reg <= ADDR_W'({p_reg[LIMIT_W-1:0], 2'b00});
        end else if (cmd.so_take) begin
            jtmp_reg <= sox_reg - mul_acc_reg[ADDR_W-1:0];
            sox_reg  <= mul_acc_reg[ADDR_W-1:0];
        end else if (cmd.sb_take) begin
            jump_reg[dim_idx] <= sbx_reg + jtmp_reg;
            sbx_reg           <= mul_acc_reg[ADDR_W-1:0];
        end
        if (cmd.str_store) begin
            stepo_reg[dim_idx] <= sox_reg;
        end
    end

    // ---------------- per sample ----------------
    always_comb begin
        carry[0] = 1'b1;
        last_now = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++) begin
            coord_max[d] = (SIZE_W'(coord_reg[d] + 1'b1) == size_eff[d]);
            to_max[d]    = (SIZE_W'(to_reg[d] + 1'b1) == td_reg[d]);
            carry[d+1]   = carry[d] && coord_max[d];
            if (used[d] && !coord_max[d]) begin
                last_now = 1'b0;
            end
        end
        sum_lo = '0;
        sum_hi = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (d < HALF) begin
                sum_lo = sum_lo + c_reg[d];
            end else begin
                sum_hi = sum_hi + c_reg[d];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cnt_init) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                coord_reg[d] <= '0;
                to_reg[d]    <= '0;
                c_reg[d]     <= (d == 0) ? ADDR_W'(hdr) : '0;
            end
        end else if (cmd.item_take) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                if (used[d] && carry[d]) begin
                    if (coord_max[d]) begin
                        coord_reg[d] <= '0;
                        to_reg[d]    <= '0;
                        c_reg[d]     <= (d == 0) ? ADDR_W'(hdr) : '0;
                    end else begin
                        coord_reg[d] <= SIZE_W'(coord_reg[d] + 1'b1);
                        if (to_max[d]) begin
                            to_reg[d] <= '0;
                            c_reg[d]  <= c_reg[d] + jump_reg[d];
                        end else begin
                            to_reg[d] <= SIZE_W'(to_reg[d] + 1'b1);
                            c_reg[d]  <= c_reg[d] + stepo_reg[d];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_take) begin
            s_lo_reg <= sum_lo;
            s_hi_reg <= sum_hi;
            last_reg <= last_now;
            word_reg <= cfg.swap_bytes ?
                        {s_sample_word[7:0], s_sample_word[15:8],
                         s_sample_word[23:16], s_sample_word[31:24]} : s_sample_word;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            addr_out_reg <= s_lo_reg + s_hi_reg;
            word_out_reg <= word_reg;
            last_out_reg <= last_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_byte_address = addr_out_reg;
    assign m_out_word     = word_out_reg;
    assign m_last_sample  = last_out_reg;

endmodule

FILE: rtl/core/tiled_array_address_generator.sv
// Two register stages: partial address sums on input transfer, then their sum in the
// output register once it is free. A new sample is taken only after the last has left
// the first stage. Tile setup after reset or any write to a defined register runs on
// the shift-add multiplier (tile size products, strides) and the restoring divider.
// Reset (aresetn low, synchronous): registers to defaults, setup pending, output empty.
module tiled_array_address_generator import taag_pkg::*; #(
    parameter int MAX_DIM_POINTS = DEF_MAX_DIM_POINTS,
    parameter int MAX_DIMS       = DEF_MAX_DIMS
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // sample input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [WORD_W-1:0]  s_sample_word,
    // address output
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ADDR_W-1:0]  m_byte_address,
    output logic [WORD_W-1:0]  m_out_word,
    output logic               m_last_sample
);

    localparam int IDX_W = (MAX_DIMS > 2) ? $clog2(MAX_DIMS) : 1;

    cfg_t             cfg;
    logic             cfg_wr;
    dp_cmd_t          cmd;
    dp_sts_t          sts;
    logic [IDX_W-1:0] dim_idx;
    logic [IDX_W-1:0] last_dim;

    // Register file; any write to a defined register forces a new tile setup.
    taag_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    // Controller: sequences the setup (halving loop, tile counts, strides)
    // and then walks each sample transfer through the two address stages.
    taag_ctrl #(
        .MAX_DIMS (MAX_DIMS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr   (cfg_wr),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .sts      (sts),
        .last_dim (last_dim),
        .cmd      (cmd),
        .dim_idx  (dim_idx)
    );

    // Datapath: per-dimension coordinate lanes keep a running address
    // contribution, so no division is needed per sample. The output register
    // lets the next sample transfer in while a result waits.
    taag_dp #(
        .MAX_DIM_POINTS (MAX_DIM_POINTS),
        .MAX_DIMS       (MAX_DIMS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .dim_idx        (dim_idx),
        .last_dim       (last_dim),
        .sts            (sts),
        .s_sample_word  (s_sample_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_address (m_byte_address),
        .m_out_word     (m_out_word),
        .m_last_sample  (m_last_sample)
    );

    // one sample in flight: no second input transfer right behind the first
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a sample is still in the address stages");

    // the output register is loaded only when empty or draining
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("pending result overwritten");

    // a register write must block input until setup has run again
    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !s_ready)
        else $error("input accepted before setup after a register write");

    // the shared multiplier is never restarted mid-operation
    a_mul_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_start |-> !sts.mul_busy)
        else $error("multiplier started while busy");

endmodule
